// ----- hdl/s2sbp_pkg.sv -----
// Package for the SECS-II sensor body parser: types, constants and helpers.
package s2sbp_pkg;

  // Largest number of sensor records taken from one body.
  localparam int unsigned MaxRecords = 32;
  localparam int unsigned SdW = $clog2(MaxRecords + 1);

  // Data item lengths, in bytes.
  localparam logic [3:0] TsLen = 4'd8;
  localparam logic [3:0] U2Len = 4'd2;
  localparam logic [3:0] F4Len = 4'd4;

  typedef logic [SdW-1:0] sd_t;

  // Parser phase: header phases, body phases (header + 7), then the two end phases.
  typedef enum logic [3:0] {
    PhRoot      = 4'd0,
    PhTs        = 4'd1,
    PhCnt       = 4'd2,
    PhList      = 4'd3,
    PhSen       = 4'd4,
    PhId        = 4'd5,
    PhVal       = 4'd6,
    PhRootBody  = 4'd7,
    PhTsBody    = 4'd8,
    PhCntBody   = 4'd9,
    PhListBody  = 4'd10,
    PhSenBody   = 4'd11,
    PhIdBody    = 4'd12,
    PhValBody   = 4'd13,
    PhDonePend  = 4'd14,
    PhIdle      = 4'd15
  } phase_e;

  // Item under parse.
  typedef enum logic [2:0] {
    ItRoot = 3'd0,
    ItTs   = 3'd1,
    ItCnt  = 3'd2,
    ItList = 3'd3,
    ItSen  = 3'd4,
    ItId   = 3'd5,
    ItVal  = 3'd6
  } item_e;

  typedef enum logic [1:0] {
    KTimestamp = 2'd0,
    KSensor    = 2'd1,
    KDone      = 2'd2,
    KError     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone = 3'd0,
    ErrTs   = 3'd1,
    ErrCnt  = 3'd2,
    ErrId   = 3'd3,
    ErrVal  = 3'd4
  } err_e;

  // Expected data length of a data item.
  function automatic logic [3:0] need_len(item_e item);
    logic [3:0] n;
    unique case (item)
      ItTs:         n = TsLen;
      ItCnt, ItId:  n = U2Len;
      default:      n = F4Len;
    endcase
    return n;
  endfunction

  // Length error code of a data item.
  function automatic err_e err_code(item_e item);
    err_e e;
    unique case (item)
      ItTs:    e = ErrTs;
      ItCnt:   e = ErrCnt;
      ItId:    e = ErrId;
      default: e = ErrVal;
    endcase
    return e;
  endfunction

  // Body phase that belongs to an item.
  function automatic phase_e body_phase(item_e item);
    return phase_e'({1'b0, item} + 4'd7);
  endfunction

endpackage

// ----- hdl/s2sbp_if.sv -----
// Stream interfaces of the SECS-II sensor body parser: body bytes in, records out.
interface s2sbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       body_start;

  modport source (output valid, data_byte, body_start, input ready);
  modport sink   (input valid, data_byte, body_start, output ready);
endinterface

interface s2sbp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [63:0] payload;
  logic [15:0] probe_id;
  logic [5:0]  sensor_index;
  logic [2:0]  error_code;
  logic        last_record;

  modport source (output valid, record_kind, payload, probe_id, sensor_index, error_code,
                  last_record, input ready);
  modport sink   (input valid, record_kind, payload, probe_id, sensor_index, error_code,
                  last_record, output ready);
endinterface

// ----- hdl/secs2_sensor_body_parser_top.sv -----
// Top level of the SECS-II sensor body parser.
// Takes a SECS-II message body one byte per transaction and emits at most one record per
// byte: the U8 timestamp, one record per sensor (U2 id plus raw F4 bits in the low 32
// payload bits), a done record after min(count, MaxRecords) sensors, or a length error
// that halts parsing until the next byte flagged body_start. The done record that follows
// the last sensor comes out on the next byte accepted, whatever that byte is; if it also
// starts a body, the byte is parsed as the new root header. Bytes after done or error are
// dropped until body_start. Rate: one byte per clock while the sink is ready. Each accepted
// byte is decoded against the parse state registers, which are written in the same cycle as
// the result register; its record is shown in the cycle after. The result register is the
// only buffer, so input ready drops only while a record waits and the sink is not ready.
module secs2_sensor_body_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  s2sbp_in_if.sink     in_if,
  s2sbp_out_if.source  out_if
);

  // Parse state
  s2sbp_pkg::phase_e phase_q, phase_d;
  logic [1:0]        lbl_q, lbl_d;      // length bytes left
  logic [23:0]       lacc_q, lacc_d;    // length accumulator
  logic [3:0]        dbl_q, dbl_d;      // data bytes left
  logic [63:0]       dacc_q, dacc_d;    // data accumulator
  logic [15:0]       exp_q, exp_d;      // expected sensor count
  s2sbp_pkg::sd_t    sd_q, sd_d;        // sensors done
  logic [15:0]       id_q, id_d;        // held sensor id

  // Result register
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [63:0] payload_q;
  logic [15:0] sid_q;
  logic [5:0]  sidx_q;
  logic [2:0]  err_q;
  logic        last_q;

  logic in_acc;
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  // ---------------------------------------------------------------------------
  // Decode of one byte against the (possibly restarted) state
  // ---------------------------------------------------------------------------
  logic              start;
  logic [7:0]        b;
  s2sbp_pkg::phase_e b_phase;
  logic [1:0]        b_lbl;
  logic [23:0]       b_lacc;
  logic [3:0]        b_dbl;
  logic [63:0]       b_dacc;
  logic [15:0]       b_exp;
  s2sbp_pkg::sd_t    b_sd;
  logic [15:0]       b_id;
  logic              is_hdr, is_body, len_step, dat_step;
  s2sbp_pkg::item_e  item;
  logic              item_list;
  logic [1:0]        lbl_n;
  logic [23:0]       lacc_n;
  logic [3:0]        dbl_n;
  logic [63:0]       dacc_n;
  logic [3:0]        need;
  logic              fin_len, fin_dat, len_ok, len_err;
  s2sbp_pkg::sd_t    lim, sd_inc;
  logic              last_sensor, cnt_zero;
  logic              done_pend;

  always_comb begin
    start     = in_if.body_start;
    b         = in_if.data_byte;
    done_pend = (phase_q == s2sbp_pkg::PhDonePend);
    // A start byte sees the reset state.
    b_phase = start ? s2sbp_pkg::PhRoot : phase_q;
    b_lbl   = start ? 2'd0  : lbl_q;
    b_lacc  = start ? 24'd0 : lacc_q;
    b_dbl   = start ? 4'd0  : dbl_q;
    b_dacc  = start ? 64'd0 : dacc_q;
    b_exp   = start ? 16'd0 : exp_q;
    b_sd    = start ? '0    : sd_q;
    b_id    = start ? 16'd0 : id_q;

    is_hdr  = (b_phase < s2sbp_pkg::PhRootBody);
    is_body = !is_hdr && (b_phase < s2sbp_pkg::PhDonePend);
    item    = is_hdr ? s2sbp_pkg::item_e'(b_phase[2:0])
                     : s2sbp_pkg::item_e'(3'(b_phase - s2sbp_pkg::PhRootBody));
    item_list = (item == s2sbp_pkg::ItRoot) || (item == s2sbp_pkg::ItList) ||
                (item == s2sbp_pkg::ItSen);

    len_step = is_body && (b_lbl != 2'd0);
    dat_step = is_body && (b_lbl == 2'd0);

    lbl_n  = is_hdr ? b[1:0] : 2'(b_lbl - 2'd1);
    lacc_n = is_hdr ? 24'd0 : {b_lacc[15:0], b};
    dbl_n  = (b_dbl == 4'd0) ? 4'd0 : 4'(b_dbl - 4'd1);
    dacc_n = {b_dacc[55:0], b};

    fin_len = (is_hdr || len_step) && (lbl_n == 2'd0);
    fin_dat = dat_step && (dbl_n == 4'd0);

    need    = s2sbp_pkg::need_len(item);
    len_ok  = (lacc_n == {20'd0, need});
    len_err = fin_len && !item_list && !len_ok;

    lim         = (b_exp < 16'(s2sbp_pkg::MaxRecords)) ? s2sbp_pkg::sd_t'(b_exp)
                                                       : s2sbp_pkg::sd_t'(s2sbp_pkg::MaxRecords);
    sd_inc      = s2sbp_pkg::sd_t'(b_sd + 1'b1);
    last_sensor = (sd_inc >= lim);
    cnt_zero    = (dacc_n[15:0] == 16'd0);
  end

  // ---------------------------------------------------------------------------
  // Next phase
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d = phase_q;
    if (in_acc) begin
      priority if (done_pend && !start) begin
        phase_d = s2sbp_pkg::PhIdle;
      end else if (fin_len) begin
        unique case (item)
          s2sbp_pkg::ItRoot: phase_d = s2sbp_pkg::PhTs;
          s2sbp_pkg::ItList: phase_d = s2sbp_pkg::PhSen;
          s2sbp_pkg::ItSen:  phase_d = s2sbp_pkg::PhId;
          default:           phase_d = len_ok ? s2sbp_pkg::body_phase(item)
                                              : s2sbp_pkg::PhIdle;
        endcase
      end else if (fin_dat) begin
        unique case (item)
          s2sbp_pkg::ItTs:  phase_d = s2sbp_pkg::PhCnt;
          s2sbp_pkg::ItCnt: phase_d = cnt_zero ? s2sbp_pkg::PhIdle : s2sbp_pkg::PhList;
          s2sbp_pkg::ItId:  phase_d = s2sbp_pkg::PhVal;
          default:          phase_d = last_sensor ? s2sbp_pkg::PhDonePend
                                                  : s2sbp_pkg::PhSen;
        endcase
      end else if (is_hdr) begin
        phase_d = s2sbp_pkg::body_phase(item);
      end else begin
        phase_d = b_phase;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    lbl_d  = lbl_q;
    lacc_d = lacc_q;
    dbl_d  = dbl_q;
    dacc_d = dacc_q;
    exp_d  = exp_q;
    sd_d   = sd_q;
    id_d   = id_q;
    if (in_acc) begin
      lbl_d  = (is_hdr || len_step) ? lbl_n : b_lbl;
      lacc_d = (is_hdr || len_step) ? lacc_n : b_lacc;
      exp_d  = (fin_dat && item == s2sbp_pkg::ItCnt) ? dacc_n[15:0] : b_exp;
      sd_d   = (fin_dat && item == s2sbp_pkg::ItVal) ? sd_inc : b_sd;
      id_d   = (fin_dat && item == s2sbp_pkg::ItId) ? dacc_n[15:0] : b_id;
      priority if (fin_len && !item_list && len_ok) begin
        dbl_d  = need;
        dacc_d = 64'd0;
      end else if (is_hdr) begin
        dbl_d  = 4'd0;
        dacc_d = b_dacc;
      end else if (dat_step) begin
        dbl_d  = dbl_n;
        dacc_d = dacc_n;
      end else begin
        dbl_d  = b_dbl;
        dacc_d = b_dacc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result of the byte
  // ---------------------------------------------------------------------------
  logic             res_valid;
  s2sbp_pkg::kind_e res_kind;
  logic [63:0]      res_payload;
  logic [15:0]      res_sid;
  logic [5:0]       res_sidx;
  s2sbp_pkg::err_e  res_err;
  logic             res_last;

  always_comb begin
    res_valid   = 1'b0;
    res_kind    = s2sbp_pkg::KTimestamp;
    res_payload = 64'd0;
    res_sid     = 16'd0;
    res_sidx    = 6'd0;
    res_err     = s2sbp_pkg::ErrNone;
    res_last    = 1'b0;
    priority if (done_pend) begin
      // Pending done goes out on whatever byte comes next.
      res_valid = 1'b1;
      res_kind  = s2sbp_pkg::KDone;
      res_sidx  = 6'(sd_q);
      res_last  = 1'b1;
    end else if (len_err) begin
      res_valid = 1'b1;
      res_kind  = s2sbp_pkg::KError;
      res_sidx  = 6'(b_sd);
      res_err   = s2sbp_pkg::err_code(item);
      res_last  = 1'b1;
    end else if (fin_dat) begin
      unique case (item)
        s2sbp_pkg::ItTs: begin
          res_valid   = 1'b1;
          res_payload = dacc_n;
        end
        s2sbp_pkg::ItCnt: begin
          res_valid = cnt_zero;
          res_kind  = s2sbp_pkg::KDone;
          res_last  = 1'b1;
        end
        s2sbp_pkg::ItVal: begin
          res_valid   = 1'b1;
          res_kind    = s2sbp_pkg::KSensor;
          res_payload = {32'd0, dacc_n[31:0]};
          res_sid     = b_id;
          res_sidx    = 6'(b_sd);
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= s2sbp_pkg::PhRoot;
      lbl_q   <= 2'd0;
      lacc_q  <= 24'd0;
      dbl_q   <= 4'd0;
      dacc_q  <= 64'd0;
      exp_q   <= 16'd0;
      sd_q    <= '0;
      id_q    <= 16'd0;
    end else begin
      phase_q <= phase_d;
      lbl_q   <= lbl_d;
      lacc_q  <= lacc_d;
      dbl_q   <= dbl_d;
      dacc_q  <= dacc_d;
      exp_q   <= exp_d;
      sd_q    <= sd_d;
      id_q    <= id_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= res_valid;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      kind_q    <= res_kind;
      payload_q <= res_payload;
      sid_q     <= res_sid;
      sidx_q    <= res_sidx;
      err_q     <= res_err;
      last_q    <= res_last;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.record_kind  = kind_q;
  assign out_if.payload      = payload_q;
  assign out_if.probe_id     = sid_q;
  assign out_if.sensor_index = sidx_q;
  assign out_if.error_code   = err_q;
  assign out_if.last_record  = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_sd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sd_q <= s2sbp_pkg::sd_t'(s2sbp_pkg::MaxRecords))
    else $error("sensor count past limit");

  a_done_after_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && done_pend) |=>
      (out_if.valid && out_if.record_kind == s2sbp_pkg::KDone && out_if.last_record))
    else $error("pending done record not emitted");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.last_record == ((out_if.record_kind == s2sbp_pkg::KDone) ||
                                             (out_if.record_kind == s2sbp_pkg::KError))))
    else $error("last_record disagrees with record kind");

  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> ((out_if.error_code != s2sbp_pkg::ErrNone) ==
                      (out_if.record_kind == s2sbp_pkg::KError)))
    else $error("error code disagrees with record kind");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == s2sbp_pkg::PhIdle && !start) |=> !out_if.valid)
    else $error("record emitted while halted");

endmodule
